// ----- rtl/core/pfb_pkg.sv -----
// shared types, codes and sizes of the page framebuffer blitter
package pfb_pkg;

  localparam int PAGES_DEF   = 8;
  localparam int COLUMNS_DEF = 128;
  localparam int PG_W        = 5;
  localparam int COL_W       = 9;
  localparam int ROW_W       = 8;

  typedef enum logic [2:0] {
    MODE_CLR_ALL  = 3'd0,
    MODE_CLR_AREA = 3'd1,
    MODE_BLIT     = 3'd2,
    MODE_SET_PIX  = 3'd3,
    MODE_GET_PIX  = 3'd4,
    MODE_RD_BYTE  = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    RMW_PASS     = 3'd0,
    RMW_AND_AREA = 3'd1,
    RMW_OR_LO    = 3'd2,
    RMW_OR_HI    = 3'd3,
    RMW_SET_BIT  = 3'd4
  } rmw_op_t;

  typedef struct packed {
    rmw_op_t           op;
    logic [2:0]        sh;
    logic [7:0]        img;
    logic [PG_W-1:0]   page;
    logic [ROW_W-1:0]  top;
    logic [ROW_W-1:0]  bottom;
  } rmw_ctl_t;

endpackage

// ----- rtl/core/pfb_in_if.sv -----
// input channel: one draw or read command word
interface pfb_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic [6:0] x;
  logic [5:0] y;
  logic [7:0] width;
  logic [6:0] height;
  logic [2:0] page_offset;
  logic [7:0] img_byte;

  modport source (output valid, mode, x, y, width, height, page_offset, img_byte,
                  input ready);
  modport sink (input valid, mode, x, y, width, height, page_offset, img_byte,
                output ready);
endinterface

// ----- rtl/core/pfb_out_if.sv -----
// result channel: one result word per command
interface pfb_out_if;
  logic       valid;
  logic       ready;
  logic       pixel;
  logic [7:0] data_byte;

  modport source (output valid, pixel, data_byte, input ready);
  modport sink (input valid, pixel, data_byte, output ready);
endinterface

// ----- rtl/core/pfb_store.sv -----
// frame store memory, one write and one registered read port
module pfb_store #(
  parameter int DEPTH = pfb_pkg::PAGES_DEF * pfb_pkg::COLUMNS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/pfb_rmw.sv -----
// shared byte modify unit: shift, mask and merge of one stored byte
module pfb_rmw (
  input  pfb_pkg::rmw_ctl_t ctl,
  input  logic [7:0]        old_byte,
  output logic [7:0]        new_byte,
  output logic              bit_out
);

  logic [15:0] img_sh;
  logic [7:0]  area_mask;
  logic [7:0]  bit_mask;

  always_comb begin
    logic [pfb_pkg::ROW_W-1:0] row;
    img_sh   = {8'h00, ctl.img} << ctl.sh;
    bit_mask = 8'h01 << ctl.sh;
    for (int b = 0; b < 8; b++) begin
      row = {ctl.page, 3'(b)};
      area_mask[b] = (row >= ctl.top) && (row < ctl.bottom);
    end
  end

  always_comb begin
    unique case (ctl.op)
      pfb_pkg::RMW_AND_AREA: new_byte = old_byte & ~area_mask;
      pfb_pkg::RMW_OR_LO:    new_byte = old_byte | img_sh[7:0];
      pfb_pkg::RMW_OR_HI:    new_byte = old_byte | img_sh[15:8];
      pfb_pkg::RMW_SET_BIT:  new_byte = old_byte | bit_mask;
      default:               new_byte = old_byte;
    endcase
  end

  assign bit_out = |(old_byte & bit_mask);

endmodule

// ----- rtl/core/page_framebuffer_blitter.sv -----
// top level: command sequencer, frame store and result register
// pixel, read and blit commands pass read and write states, blit twice for a nonzero
// shift, clear area once per touched column byte; clear all wipes every byte, others
// go straight to done; one command in flight, next accept in the cycle after the
// result loads; one store, one write port; after reset a clearing pass writes zero
// to all PAGES*COLUMNS bytes, one per cycle, and no command is accepted until it ends
module page_framebuffer_blitter #(
  parameter int PAGES   = pfb_pkg::PAGES_DEF,
  parameter int COLUMNS = pfb_pkg::COLUMNS_DEF
) (
  input logic      clk,
  input logic      rst_n,
  pfb_in_if.sink   in_ch,
  pfb_out_if.source out_ch
);

  localparam int DEPTH = PAGES * COLUMNS;
  localparam int AW    = $clog2(DEPTH);
  localparam int ROWS  = PAGES * 8;

  typedef enum logic [4:0] {
    S_WIPE = 5'b00001,
    S_IDLE = 5'b00010,
    S_RD   = 5'b00100,
    S_WR   = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t                          state_r, state_nxt;
  logic [AW-1:0]                   wipe_cnt_r, wipe_cnt_nxt;
  logic                            wipe_res_r, wipe_res_nxt;
  logic                            part_r, part_nxt;
  pfb_pkg::mode_t                  mode_r, mode_nxt;
  logic [pfb_pkg::COL_W-1:0]       x_r, x_nxt;
  logic [pfb_pkg::COL_W-1:0]       col_r, col_nxt;
  logic [pfb_pkg::COL_W-1:0]       col_end_r, col_end_nxt;
  logic [pfb_pkg::PG_W-1:0]        page_r, page_nxt;
  logic [pfb_pkg::PG_W-1:0]        page_last_r, page_last_nxt;
  logic [pfb_pkg::ROW_W-1:0]       top_r, top_nxt;
  logic [pfb_pkg::ROW_W-1:0]       bottom_r, bottom_nxt;
  logic [2:0]                      sh_r, sh_nxt;
  logic [7:0]                      img_r, img_nxt;
  logic                            res_pix_r, res_pix_nxt;
  logic [7:0]                      res_data_r, res_data_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic                            out_pix_r, out_pix_nxt;
  logic [7:0]                      out_data_r, out_data_nxt;

  logic                            in_rng;
  logic [AW-1:0]                   addr;
  logic                            st_we;
  logic [AW-1:0]                   st_waddr;
  logic [7:0]                      st_wdata;
  logic                            st_re;
  logic [7:0]                      rd_data;
  pfb_pkg::rmw_ctl_t               rmw_ctl;
  logic [7:0]                      rmw_byte;
  logic                            rmw_bit;
  logic                            out_load;
  logic                            accept;

  // accept-time decode
  logic [pfb_pkg::COL_W-1:0]       a_x_end;
  logic [pfb_pkg::ROW_W-1:0]       a_y_end;
  logic [pfb_pkg::ROW_W-1:0]       a_last_row;
  logic [pfb_pkg::PG_W-1:0]        a_last_pg;
  logic                            a_empty;

  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);

  assign in_rng = (page_r < pfb_pkg::PG_W'(PAGES)) && (col_r < pfb_pkg::COL_W'(COLUMNS));
  assign addr   = in_rng ? AW'(32'(page_r) * COLUMNS + 32'(col_r)) : '0;

  assign a_x_end    = pfb_pkg::COL_W'(in_ch.x) + pfb_pkg::COL_W'(in_ch.width);
  assign a_y_end    = pfb_pkg::ROW_W'(in_ch.y) + pfb_pkg::ROW_W'(in_ch.height);
  assign a_last_row = a_y_end - 1'b1;
  assign a_last_pg  = pfb_pkg::PG_W'(a_last_row[pfb_pkg::ROW_W-1:3]);
  assign a_empty    = (in_ch.width == '0) || (in_ch.height == '0) ||
                      (pfb_pkg::COL_W'(in_ch.x) >= pfb_pkg::COL_W'(COLUMNS)) ||
                      (pfb_pkg::ROW_W'(in_ch.y) >= pfb_pkg::ROW_W'(ROWS));

  always_comb begin
    rmw_ctl.op     = pfb_pkg::RMW_PASS;
    rmw_ctl.sh     = sh_r;
    rmw_ctl.img    = img_r;
    rmw_ctl.page   = page_r;
    rmw_ctl.top    = top_r;
    rmw_ctl.bottom = bottom_r;
    unique case (mode_r)
      pfb_pkg::MODE_CLR_AREA: rmw_ctl.op = pfb_pkg::RMW_AND_AREA;
      pfb_pkg::MODE_BLIT:     rmw_ctl.op = part_r ? pfb_pkg::RMW_OR_HI : pfb_pkg::RMW_OR_LO;
      pfb_pkg::MODE_SET_PIX:  rmw_ctl.op = pfb_pkg::RMW_SET_BIT;
      default:                rmw_ctl.op = pfb_pkg::RMW_PASS;
    endcase
  end

  pfb_rmw u_rmw (
    .ctl      (rmw_ctl),
    .old_byte (rd_data),
    .new_byte (rmw_byte),
    .bit_out  (rmw_bit)
  );

  always_comb begin
    st_re    = (state_r == S_RD);
    st_we    = 1'b0;
    st_waddr = addr;
    st_wdata = rmw_byte;
    if (state_r == S_WIPE) begin
      st_we    = 1'b1;
      st_waddr = wipe_cnt_r;
      st_wdata = 8'h00;
    end else if (state_r == S_WR) begin
      st_we = in_rng && ((mode_r == pfb_pkg::MODE_CLR_AREA) ||
                         (mode_r == pfb_pkg::MODE_BLIT) ||
                         (mode_r == pfb_pkg::MODE_SET_PIX));
    end
  end

  pfb_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (st_re),
    .raddr (addr),
    .rdata (rd_data)
  );

  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt     = state_r;
    wipe_cnt_nxt  = wipe_cnt_r;
    wipe_res_nxt  = wipe_res_r;
    part_nxt      = part_r;
    mode_nxt      = mode_r;
    x_nxt         = x_r;
    col_nxt       = col_r;
    col_end_nxt   = col_end_r;
    page_nxt      = page_r;
    page_last_nxt = page_last_r;
    top_nxt       = top_r;
    bottom_nxt    = bottom_r;
    sh_nxt        = sh_r;
    img_nxt       = img_r;
    res_pix_nxt   = res_pix_r;
    res_data_nxt  = res_data_r;
    out_valid_nxt = out_valid_r;
    out_pix_nxt   = out_pix_r;
    out_data_nxt  = out_data_r;

    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_pix_nxt   = res_pix_r;
      out_data_nxt  = res_data_r;
    end

    unique case (state_r)
      S_WIPE: begin
        if (wipe_cnt_r == AW'(DEPTH - 1)) begin
          state_nxt = wipe_res_r ? S_DONE : S_IDLE;
        end else begin
          wipe_cnt_nxt = wipe_cnt_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (accept) begin
          mode_nxt      = pfb_pkg::mode_t'(in_ch.mode);
          x_nxt         = pfb_pkg::COL_W'(in_ch.x);
          col_nxt       = pfb_pkg::COL_W'(in_ch.x);
          col_end_nxt   = (a_x_end > pfb_pkg::COL_W'(COLUMNS)) ?
                          pfb_pkg::COL_W'(COLUMNS) : a_x_end;
          page_last_nxt = (a_last_pg > pfb_pkg::PG_W'(PAGES - 1)) ?
                          pfb_pkg::PG_W'(PAGES - 1) : a_last_pg;
          top_nxt       = pfb_pkg::ROW_W'(in_ch.y);
          bottom_nxt    = a_y_end;
          sh_nxt        = in_ch.y[2:0];
          img_nxt       = in_ch.img_byte;
          part_nxt      = 1'b0;
          res_pix_nxt   = 1'b0;
          res_data_nxt  = 8'h00;
          page_nxt      = pfb_pkg::PG_W'(in_ch.y[5:3]);
          unique case (pfb_pkg::mode_t'(in_ch.mode))
            pfb_pkg::MODE_CLR_ALL: begin
              wipe_cnt_nxt = '0;
              wipe_res_nxt = 1'b1;
              state_nxt    = S_WIPE;
            end
            pfb_pkg::MODE_CLR_AREA: begin
              state_nxt = a_empty ? S_DONE : S_RD;
            end
            pfb_pkg::MODE_BLIT: begin
              page_nxt  = pfb_pkg::PG_W'(in_ch.y[5:3]) + pfb_pkg::PG_W'(in_ch.page_offset);
              state_nxt = S_RD;
            end
            pfb_pkg::MODE_SET_PIX, pfb_pkg::MODE_GET_PIX: begin
              state_nxt = S_RD;
            end
            pfb_pkg::MODE_RD_BYTE: begin
              page_nxt  = pfb_pkg::PG_W'(in_ch.page_offset);
              state_nxt = S_RD;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_RD: begin
        state_nxt = S_WR;
      end
      S_WR: begin
        state_nxt = S_DONE;
        unique case (mode_r)
          pfb_pkg::MODE_CLR_AREA: begin
            if ((col_r + 1'b1) < col_end_r) begin
              col_nxt   = col_r + 1'b1;
              state_nxt = S_RD;
            end else if (page_r < page_last_r) begin
              page_nxt  = page_r + 1'b1;
              col_nxt   = x_r;
              state_nxt = S_RD;
            end
          end
          pfb_pkg::MODE_BLIT: begin
            if (!part_r && (sh_r != 3'd0)) begin
              part_nxt  = 1'b1;
              page_nxt  = page_r + 1'b1;
              state_nxt = S_RD;
            end
          end
          pfb_pkg::MODE_GET_PIX: begin
            res_pix_nxt = in_rng && rmw_bit;
          end
          pfb_pkg::MODE_RD_BYTE: begin
            res_data_nxt = in_rng ? rd_data : 8'h00;
          end
          default: begin
          end
        endcase
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_WIPE;
      wipe_cnt_r  <= '0;
      wipe_res_r  <= 1'b0;
      part_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wipe_cnt_r  <= wipe_cnt_nxt;
      wipe_res_r  <= wipe_res_nxt;
      part_r      <= part_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r      <= mode_nxt;
    x_r         <= x_nxt;
    col_r       <= col_nxt;
    col_end_r   <= col_end_nxt;
    page_r      <= page_nxt;
    page_last_r <= page_last_nxt;
    top_r       <= top_nxt;
    bottom_r    <= bottom_nxt;
    sh_r        <= sh_nxt;
    img_r       <= img_nxt;
    res_pix_r   <= res_pix_nxt;
    res_data_r  <= res_data_nxt;
    out_pix_r   <= out_pix_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.pixel     = out_pix_r;
  assign out_ch.data_byte = out_data_r;

  a_no_accept_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ch.ready)
    else $error("word accepted before store clearing pass");

  a_write_only_when_owned: assert property (@(posedge clk) disable iff (!rst_n)
    st_we |-> (state_r == S_WR || state_r == S_WIPE))
    else $error("store written outside write or clear cycle");

  a_area_clear_no_set: assert property (@(posedge clk) disable iff (!rst_n)
    (st_we && state_r == S_WR && mode_r == pfb_pkg::MODE_CLR_AREA) |->
      ((st_wdata & ~rd_data) == 8'h00))
    else $error("area clear set a pixel");

  a_result_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> (out_valid_r && $stable(out_data_r) &&
                                        $stable(out_pix_r)))
    else $error("pending result word overwritten");

endmodule
